// File: rtl/k3f_pkg.sv
// Shared types and constants of the 3x3 image filter core.
// Used by the front, back and top modules; depends on nothing else.
package k3f_pkg;

	// Default line buffer depth and the largest frame height the block handles.
	localparam int K3F_MAX_WIDTH  = 1024;
	localparam int K3F_MAX_HEIGHT = 4095;

	// Queue depths between front and back, and in front of the result port.
	localparam int K3F_FQ_DEPTH = 4;
	localparam int K3F_OQ_DEPTH = 4;

	// Configuration port.
	localparam int CFG_INDEX_W  = 1;
	localparam int CFG_DATA_W   = 12;
	localparam int CFG_WIDTH_W  = 11;
	localparam int CFG_HEIGHT_W = 12;

	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

	localparam logic [CFG_WIDTH_W-1:0]  CFG_WIDTH_RESET  = 11'd640;
	localparam logic [CFG_HEIGHT_W-1:0] CFG_HEIGHT_RESET = 12'd480;

	// Input operation codes.
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	// Cycles after a configuration write before the frame size is settled.
	localparam logic [1:0] SETTLE_CYCLES = 2'd2;

	// Reciprocal of nine in 16 fractional bits, exact for magnitudes up to 510.
	localparam logic [13:0] RECIP_NINE = 14'd7282;

	// Classified command handed from the front to the back.
	typedef enum logic [1:0] {
		CMD_PIXEL_QUIET = 2'd0,
		CMD_PIXEL_EMIT  = 2'd1,
		CMD_FLUSH_EMIT  = 2'd2
	} k3f_op_t;

	typedef struct packed {
		k3f_op_t    op;
		logic       interior;
		logic       last;
		logic [7:0] px;
	} k3f_cmd_t;

	typedef struct packed {
		logic signed [6:0] value;
		logic              last;
	} k3f_result_t;

endpackage

// File: rtl/k3f_queue.sv
// Small first-in first-out queue built from registers.
// Generic; used between front and back and in front of the result port.
module k3f_queue #(
	parameter int DEPTH = 4,
	parameter int WIDTH = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           push_data,
	input  logic                       pop,
	output logic [WIDTH-1:0]           pop_data,
	output logic                       empty,
	output logic                       full,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [NW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign empty    = (count_q == '0);
	assign full     = (count_q == NW'(DEPTH));
	assign count    = count_q;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + NW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: rtl/k3f_front.sv
// Front of the filter: configuration registers, pixel and result position counters,
// and classification of each accepted word into a back-end command. Uses k3f_pkg.
module k3f_front #(
	parameter int MAX_WIDTH = k3f_pkg::K3F_MAX_WIDTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [k3f_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [k3f_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 operation,
	input  logic [7:0]                           pixel,
	input  logic                                 fq_full,
	output logic                                 fq_push,
	output k3f_pkg::k3f_cmd_t                    cmd,
	output logic [$clog2(MAX_WIDTH)-1:0]         col
);

	import k3f_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int PW = $clog2(MAX_WIDTH * K3F_MAX_HEIGHT);

	logic [CFG_WIDTH_W-1:0]  cfg_width_q;
	logic [CFG_HEIGHT_W-1:0] cfg_height_q;
	logic [1:0]              settle_q;
	logic [WW-1:0]           eff_w_q;
	logic [CFG_HEIGHT_W-1:0] eff_h_q;
	logic [PW-1:0]           last_pos_q;

	logic [CW-1:0]           col_q;
	logic [CFG_HEIGHT_W-1:0] row_q;
	logic [PW-1:0]           pos_q;

	logic [WW-1:0]           eff_w_d;
	logic [CFG_HEIGHT_W-1:0] eff_h_d;
	logic                    accept;
	logic                    is_pixel;
	logic                    at_start;
	logic                    produce;
	logic                    interior;
	logic                    line_end;
	logic [PW-1:0]           pos;
	logic [PW-1:0]           pos_adv;

	always_comb begin
		if (cfg_width_q < CFG_WIDTH_W'(3)) begin
			eff_w_d = WW'(3);
		end else if (int'(cfg_width_q) > MAX_WIDTH) begin
			eff_w_d = WW'(MAX_WIDTH);
		end else begin
			eff_w_d = WW'(cfg_width_q);
		end
		eff_h_d = (cfg_height_q < CFG_HEIGHT_W'(3)) ? CFG_HEIGHT_W'(3) : cfg_height_q;
	end

	assign in_ready = !fq_full && (settle_q == 2'd0);
	assign accept   = in_valid && in_ready;
	assign is_pixel = (operation == OP_PIXEL);
	assign at_start = (row_q == '0) && (col_q == '0);
	assign line_end = (WW'(col_q) >= eff_w_q - WW'(1));

	always_comb begin
		// A pixel at the frame start discards whatever the previous frame left pending.
		pos = (is_pixel && at_start) ? '0 : pos_q;
		if (is_pixel) begin
			produce  = (row_q >= CFG_HEIGHT_W'(2)) || ((row_q == CFG_HEIGHT_W'(1)) && (col_q != '0));
			interior = (row_q >= CFG_HEIGHT_W'(2)) && (row_q <= eff_h_q - CFG_HEIGHT_W'(1))
			        && (WW'(col_q) >= WW'(2)) && (WW'(col_q) <= eff_w_q - WW'(1));
		end else begin
			produce  = at_start && (pos_q != '0);
			interior = 1'b0;
		end
		pos_adv = (pos >= last_pos_q) ? '0 : pos + PW'(1);
	end

	assign fq_push      = accept && (is_pixel || produce);
	assign cmd.op       = !is_pixel ? CMD_FLUSH_EMIT : (produce ? CMD_PIXEL_EMIT : CMD_PIXEL_QUIET);
	assign cmd.interior = interior;
	assign cmd.last     = (pos == last_pos_q);
	assign cmd.px       = pixel;
	assign col          = col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_width_q  <= CFG_WIDTH_RESET;
			cfg_height_q <= CFG_HEIGHT_RESET;
			settle_q     <= SETTLE_CYCLES;
			col_q        <= '0;
			row_q        <= '0;
			pos_q        <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_IMAGE_WIDTH:  cfg_width_q  <= cfg_data[CFG_WIDTH_W-1:0];
					REG_IMAGE_HEIGHT: cfg_height_q <= cfg_data[CFG_HEIGHT_W-1:0];
					default: ;
				endcase
				settle_q <= SETTLE_CYCLES;
			end else if (settle_q != 2'd0) begin
				settle_q <= settle_q - 2'd1;
			end

			if (accept) begin
				if (is_pixel) begin
					if (line_end) begin
						col_q <= '0;
						row_q <= (row_q >= eff_h_q - CFG_HEIGHT_W'(1)) ? '0
						         : row_q + CFG_HEIGHT_W'(1);
					end else begin
						col_q <= col_q + CW'(1);
					end
				end
				if (produce) begin
					pos_q <= pos_adv;
				end else begin
					pos_q <= pos;
				end
			end
		end
	end

	// The frame size is pipelined through eff_w_q/eff_h_q and then last_pos_q; settle_q holds input off meanwhile.
	always_ff @(posedge clk) begin
		eff_w_q    <= eff_w_d;
		eff_h_q    <= eff_h_d;
		last_pos_q <= PW'(eff_w_q * eff_h_q - 1);
	end

endmodule

// File: rtl/k3f_back.sv
// Back of the filter: line buffer memory, window registers, kernel sum and
// division by nine. Takes commands from the front queue; uses k3f_pkg.
module k3f_back #(
	parameter int MAX_WIDTH = k3f_pkg::K3F_MAX_WIDTH,
	parameter int OQ_DEPTH  = k3f_pkg::K3F_OQ_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            fq_empty,
	input  k3f_pkg::k3f_cmd_t               fq_cmd,
	input  logic [$clog2(MAX_WIDTH)-1:0]    fq_col,
	output logic                            fq_pop,
	input  logic [$clog2(OQ_DEPTH+1)-1:0]   oq_count,
	output logic                            oq_push,
	output k3f_pkg::k3f_result_t            oq_data
);

	import k3f_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);

	// Each word holds the column's pixel one line up (high byte) and two lines up.
	logic [15:0] line_mem [MAX_WIDTH];

	logic              v_s1;
	k3f_cmd_t          cmd_s1;
	logic [CW-1:0]     col_s1;
	logic [15:0]       rd_s1;
	logic              v_s2;
	logic signed [9:0] sum_s2;
	logic              last_s2;

	logic [7:0]        top_c1_q;
	logic [7:0]        top_c2_q;
	logic [7:0]        bot_c1_q;
	logic [7:0]        bot_c2_q;

	logic              credit;
	logic              is_pixel;
	logic              emit;
	logic signed [9:0] sum;
	logic              neg;
	logic [8:0]        mag;
	logic [22:0]       prod;
	logic [5:0]        quot;

	// Every item in flight is counted against the result queue, so the stages never stall.
	assign credit = (int'(oq_count) + int'(v_s1) + int'(v_s2)) < OQ_DEPTH;
	assign fq_pop = !fq_empty && credit;

	always_comb begin
		unique case (cmd_s1.op)
			CMD_PIXEL_QUIET: begin
				is_pixel = 1'b1;
				emit     = 1'b0;
			end
			CMD_PIXEL_EMIT: begin
				is_pixel = 1'b1;
				emit     = 1'b1;
			end
			CMD_FLUSH_EMIT: begin
				is_pixel = 1'b0;
				emit     = 1'b1;
			end
			default: begin
				is_pixel = 1'b0;
				emit     = 1'b0;
			end
		endcase
	end

	// Corners of the shifted window: oldest and newest column of the top and bottom rows.
	assign sum = $signed({2'b00, rd_s1[7:0]}) - $signed({2'b00, top_c1_q})
	           + $signed({2'b00, bot_c1_q}) - $signed({2'b00, cmd_s1.px});

	always_ff @(posedge clk) begin
		if (fq_pop) begin
			rd_s1 <= line_mem[fq_col];
		end
		if (v_s1 && is_pixel) begin
			line_mem[col_s1] <= {cmd_s1.px, rd_s1[15:8]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			top_c1_q <= '0;
			top_c2_q <= '0;
			bot_c1_q <= '0;
			bot_c2_q <= '0;
		end else begin
			v_s1 <= fq_pop;
			v_s2 <= v_s1 && emit;
			if (v_s1 && is_pixel) begin
				top_c1_q <= top_c2_q;
				top_c2_q <= rd_s1[7:0];
				bot_c1_q <= bot_c2_q;
				bot_c2_q <= cmd_s1.px;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fq_pop) begin
			cmd_s1 <= fq_cmd;
			col_s1 <= fq_col;
		end
		if (v_s1) begin
			sum_s2  <= cmd_s1.interior ? sum : '0;
			last_s2 <= cmd_s1.last;
		end
	end

	// Division by nine on the magnitude, so that the quotient truncates toward zero.
	always_comb begin
		neg  = sum_s2[9];
		mag  = neg ? 9'(-sum_s2) : 9'(sum_s2);
		prod = mag * RECIP_NINE;
		quot = prod[21:16];
	end

	assign oq_push       = v_s2;
	assign oq_data.value = neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
	assign oq_data.last  = last_s2;

endmodule

// File: rtl/kernel_3x3_image_filter_core.sv
// Top level of the 3x3 image filter: front, command queue, back and result queue.
// Depends on k3f_pkg, k3f_queue, k3f_front and k3f_back.

// While in_ready is high, the core takes one word per clock cycle, pixels in raster
// order or flush ticks; it returns one signed result per frame position: the corner
// kernel sum of an interior pixel divided by nine, truncated toward zero, and zero
// on the border. The result of a position comes out once the pixel one line and
// one pixel later has been taken; after the last pixel of a frame, width plus one
// flush ticks deliver the remaining border zeros, and last_of_frame marks the final
// position. A result goes from the command queue via the back's s1 and s2 registers
// into the result queue, whose non-empty state drives out_valid. The line buffer
// memory is read and written once per cycle, which sets the rate of one word per
// cycle while in_ready is high. After each configuration write, in_ready stays low
// while the frame size is recomputed; there is no clearing pass after reset.
module kernel_3x3_image_filter_core #(
	parameter int MAX_WIDTH = k3f_pkg::K3F_MAX_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [k3f_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [k3f_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             operation,
	input  logic [7:0]                       pixel,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [6:0]                filtered_value,
	output logic                             last_of_frame
);

	import k3f_pkg::*;

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int FQ_W = CW + $bits(k3f_cmd_t);
	localparam int OQ_W = $bits(k3f_result_t);

	k3f_cmd_t                        front_cmd;
	logic [CW-1:0]                   front_col;
	logic                            fq_push;
	logic                            fq_pop;
	logic                            fq_empty;
	logic                            fq_full;
	logic [FQ_W-1:0]                 fq_pop_data;
	logic [$clog2(K3F_FQ_DEPTH+1)-1:0] fq_count;
	k3f_cmd_t                        back_cmd;
	logic [CW-1:0]                   back_col;

	logic                            oq_push;
	logic                            oq_empty;
	logic                            oq_full;
	k3f_result_t                     oq_push_data;
	k3f_result_t                     oq_pop_data;
	logic [$clog2(K3F_OQ_DEPTH+1)-1:0] oq_count;

	k3f_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.pixel     (pixel),
		.fq_full   (fq_full),
		.fq_push   (fq_push),
		.cmd       (front_cmd),
		.col       (front_col)
	);

	k3f_queue #(
		.DEPTH (K3F_FQ_DEPTH),
		.WIDTH (FQ_W)
	) u_cmd_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fq_push),
		.push_data ({front_col, front_cmd}),
		.pop       (fq_pop),
		.pop_data  (fq_pop_data),
		.empty     (fq_empty),
		.full      (fq_full),
		.count     (fq_count)
	);

	assign {back_col, back_cmd} = fq_pop_data;

	k3f_back #(
		.MAX_WIDTH (MAX_WIDTH),
		.OQ_DEPTH  (K3F_OQ_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.fq_empty (fq_empty),
		.fq_cmd   (back_cmd),
		.fq_col   (back_col),
		.fq_pop   (fq_pop),
		.oq_count (oq_count),
		.oq_push  (oq_push),
		.oq_data  (oq_push_data)
	);

	k3f_queue #(
		.DEPTH (K3F_OQ_DEPTH),
		.WIDTH (OQ_W)
	) u_result_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (oq_push),
		.push_data (oq_push_data),
		.pop       (out_ready),
		.pop_data  (oq_pop_data),
		.empty     (oq_empty),
		.full      (oq_full),
		.count     (oq_count)
	);

	assign out_valid      = !oq_empty;
	assign filtered_value = oq_pop_data.value;
	assign last_of_frame  = oq_pop_data.last;

	// The front must never offer a command that the queue cannot take.
	a_cmd_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(fq_push && fq_full))
		else $error("command pushed into a full queue");

	// The back's credit check must keep the result queue from overflowing.
	a_result_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(oq_push && oq_full))
		else $error("result pushed into a full queue");

	// The back may only take a command that is there.
	a_cmd_queue_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(fq_pop && fq_empty))
		else $error("command popped from an empty queue");

	// Occupancy of both queues can never exceed their depths.
	a_queue_counts_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(fq_count) <= K3F_FQ_DEPTH) && (int'(oq_count) <= K3F_OQ_DEPTH))
		else $error("queue occupancy out of range");

endmodule
